// ===== src/crd_pkg.sv =====
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types and constants of the capture record deframer.
// ----------------------------------------------------------------------------
package crd_pkg;

  // Default width of the payload length count
  localparam int CRD_LENGTH_BITS = 16;
  localparam logic [15:0] CRD_MAX_COPY_RST = 16'hFFFF;

  // Record header layout (byte offsets from the first header byte)
  localparam int CRD_SIZE_B0    = 12;
  localparam int CRD_SIZE_B1    = 13;
  localparam int CRD_SIZE_B2    = 14;
  localparam int CRD_SIZE_B3    = 15;
  localparam int CRD_ERR_BYTE   = 20;
  localparam int CRD_POWER_BYTE = 27;
  localparam int CRD_HDR_BYTES  = 34;
  localparam int CRD_HDR2_BYTES = 14;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PAD     = 2'd2,
    PH_SKIP    = 2'd3
  } crd_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } crd_item_t;

  typedef struct packed {
    logic [7:0]        payload_byte;
    logic              last_of_packet;
    logic signed [7:0] signal_power;
    logic [15:0]       copied_length;
    logic              malformed;
  } crd_result_t;

endpackage

// ===== src/crd_ifs.sv =====
// ----------------------------------------------------------------------------
// crd_ifs
// Valid/ready channels of the deframer: byte input, result output, config.
// ----------------------------------------------------------------------------
interface crd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_last;

  modport source (output valid, data_byte, chunk_last, input ready);
  modport sink   (input valid, data_byte, chunk_last, output ready);
endinterface

interface crd_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        payload_byte;
  logic              last_of_packet;
  logic signed [7:0] signal_power;
  logic [15:0]       copied_length;
  logic              malformed;

  modport source (output valid, payload_byte, last_of_packet, signal_power,
                  copied_length, malformed, input ready);
  modport sink   (input valid, payload_byte, last_of_packet, signal_power,
                  copied_length, malformed, output ready);
endinterface

interface crd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_copy_len;

  modport source (output valid, max_copy_len, input ready);
  modport sink   (input valid, max_copy_len, output ready);
endinterface

// ===== src/crd_in_stage.sv =====
// ----------------------------------------------------------------------------
// crd_in_stage
// Input register: holds one accepted word until the parser consumes it.
// ----------------------------------------------------------------------------
module crd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  crd_in_if.sink            in_if,
  input  logic              advance,
  output logic              item_valid,
  output crd_pkg::crd_item_t item
);
  import crd_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  crd_item_t item_r;
  logic      accept;

  // Take a new word when empty or whenever the held one leaves in this cycle
  assign in_if.ready = !valid_r || advance;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte  <= in_if.data_byte;
      item_r.chunk_last <= in_if.chunk_last;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/crd_parser.sv =====
// ----------------------------------------------------------------------------
// crd_parser
// Record parser: walks header, payload and padding one byte per step and
// forms at most one result per byte.
// ----------------------------------------------------------------------------
module crd_parser #(
  parameter int LENGTH_BITS = crd_pkg::CRD_LENGTH_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic                 item_valid,
  input  crd_pkg::crd_item_t   item,
  input  logic                 advance,
  output logic                 res_valid,
  output crd_pkg::crd_result_t res
);
  import crd_pkg::*;

  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  crd_phase_t             phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]             pad_r, pad_nxt;
  logic [23:0]            slice_r;
  logic [LENGTH_BITS-1:0] plen_r;
  logic                   crc_r;
  logic [7:0]             power_r;
  logic [15:0]            max_copy_r;

  logic                   step;
  logic [7:0]             d;
  logic                   last;
  logic [31:0]            slice_full;
  logic [31:0]            plen_full;
  logic                   bad;
  logic                   at_size_end;
  logic [CW-1:0]          idx_w, plen_w, max_w, cap_w, idx_inc;
  logic                   emit;
  logic                   fin;
  logic                   pay_end;
  logic [1:0]             pad_amt;

  assign step = item_valid && advance;
  assign d    = item.data_byte;
  assign last = item.chunk_last;

  // Slice size check when its top byte arrives
  assign slice_full  = {d, slice_r};
  assign plen_full   = slice_full - 32'(CRD_HDR2_BYTES);
  assign at_size_end = (cnt_r == LENGTH_BITS'(CRD_SIZE_B3));
  assign bad = slice_full[31] || (slice_full <= 32'(CRD_HDR2_BYTES))
               || ((plen_full >> LENGTH_BITS) != 32'd0);

  // Payload position against the copy limit
  assign idx_w   = CW'(cnt_r);
  assign plen_w  = CW'(plen_r);
  assign max_w   = CW'(max_copy_r);
  assign cap_w   = (plen_w < max_w) ? plen_w : max_w;
  assign idx_inc = idx_w + CW'(1);
  assign emit    = !crc_r && (idx_w < cap_w);
  assign fin     = (idx_inc == cap_w) || last;
  assign pay_end = (idx_inc == plen_w);
  assign pad_amt = 2'd0 - slice_r[1:0];

  // Next phase, byte count and padding count
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pad_nxt   = pad_r;
    unique case (phase_r)
      PH_HEADER: begin
        cnt_nxt = cnt_r + LENGTH_BITS'(1);
        if (at_size_end) begin
          if (bad) begin
            phase_nxt = PH_SKIP;
          end
        end else if (cnt_r == LENGTH_BITS'(CRD_HDR_BYTES - 1)) begin
          phase_nxt = PH_PAYLOAD;
          cnt_nxt   = '0;
        end
      end
      PH_PAYLOAD: begin
        cnt_nxt = cnt_r + LENGTH_BITS'(1);
        if (pay_end) begin
          if (pad_amt != 2'd0) begin
            phase_nxt = PH_PAD;
            pad_nxt   = pad_amt;
          end else begin
            phase_nxt = PH_HEADER;
            cnt_nxt   = '0;
          end
        end
      end
      PH_PAD: begin
        pad_nxt = pad_r - 2'd1;
        if (pad_r == 2'd1) begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = '0;
        end
      end
      PH_SKIP: begin
        phase_nxt = PH_SKIP;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
    // End of chunk always returns to a header
    if (last) begin
      phase_nxt = PH_HEADER;
      cnt_nxt   = '0;
      pad_nxt   = 2'd0;
    end
  end

  // Result of the current byte
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_HEADER: begin
        if (at_size_end && bad) begin
          res_valid     = 1'b1;
          res.malformed = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (emit) begin
          res_valid          = 1'b1;
          res.payload_byte   = d;
          res.last_of_packet = fin;
          res.signal_power   = power_r;
          res.copied_length  = fin ? idx_inc[15:0] : 16'd0;
        end
      end
      PH_PAD, PH_SKIP: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_r      <= '0;
      pad_r      <= 2'd0;
      crc_r      <= 1'b0;
      max_copy_r <= CRD_MAX_COPY_RST;
    end else begin
      if (step) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        pad_r   <= pad_nxt;
        if (phase_r == PH_HEADER && cnt_r == LENGTH_BITS'(CRD_ERR_BYTE)) begin
          crc_r <= d[0];
        end
      end
      if (cfg_we) begin
        max_copy_r <= cfg_data;
      end
    end
  end

  // Header fields
  always_ff @(posedge clk) begin
    if (step && phase_r == PH_HEADER) begin
      if (cnt_r == LENGTH_BITS'(CRD_SIZE_B0)) begin
        slice_r[7:0] <= d;
      end
      if (cnt_r == LENGTH_BITS'(CRD_SIZE_B1)) begin
        slice_r[15:8] <= d;
      end
      if (cnt_r == LENGTH_BITS'(CRD_SIZE_B2)) begin
        slice_r[23:16] <= d;
      end
      if (at_size_end) begin
        plen_r <= plen_full[LENGTH_BITS-1:0];
      end
      if (cnt_r == LENGTH_BITS'(CRD_POWER_BYTE)) begin
        power_r <= d;
      end
    end
  end

endmodule

// ===== src/crd_out_stage.sv =====
// ----------------------------------------------------------------------------
// crd_out_stage
// Result register: holds a finished word until the receiver takes it.
// ----------------------------------------------------------------------------
module crd_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  crd_pkg::crd_result_t res,
  output logic                 can_take,
  crd_out_if.source            out_if
);
  import crd_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  crd_result_t res_r;

  // Free when empty or when the held word leaves now
  assign can_take = !valid_r || out_if.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_if.valid          = valid_r;
  assign out_if.payload_byte   = res_r.payload_byte;
  assign out_if.last_of_packet = res_r.last_of_packet;
  assign out_if.signal_power   = res_r.signal_power;
  assign out_if.copied_length  = res_r.copied_length;
  assign out_if.malformed      = res_r.malformed;

endmodule

// ===== src/capture_record_deframer.sv =====
// ----------------------------------------------------------------------------
// capture_record_deframer
// Splits a capture byte stream into records and passes on their payload.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   carries one stream byte per word with chunk_last on the final
//           byte of a read chunk.
//   out_if  carries payload bytes with the record's power value, a last
//           mark and copied count on the final byte, or a malformed report.
//   cfg_if  writes max_copy_len; always ready, write only while idle.
// Path: a taken byte waits in the input register, and its result word is
// loaded into the result register when the parser steps that byte.
// Throughput: one byte per cycle while no held result is stalled, set by the
// parser step between the two registers; bytes that make no result still take a step.
// Reset: parser returns to the record header, max_copy_len becomes 65535,
// both registers empty.
// Stall: while out_if.ready is low and a result is held, the parser holds
// its byte and in_if.ready drops once the input register is full.
// ----------------------------------------------------------------------------
module capture_record_deframer #(
  parameter int LENGTH_BITS = crd_pkg::CRD_LENGTH_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  crd_in_if.sink    in_if,
  crd_out_if.source out_if,
  crd_cfg_if.sink   cfg_if
);
  import crd_pkg::*;

  logic        item_valid;
  crd_item_t   item;
  logic        advance;
  logic        res_valid;
  crd_result_t res;

  // Configuration is taken at once
  assign cfg_if.ready = 1'b1;

  crd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  crd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_if.valid),
    .cfg_data   (cfg_if.max_copy_len),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .res_valid  (res_valid),
    .res        (res)
  );

  crd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (item_valid && advance && res_valid),
    .res      (res),
    .can_take (advance),
    .out_if   (out_if)
  );

endmodule
